// ----- rtl/pulse_count_backlight_dimmer_macros.svh -----
// Assertion macros used by the checker file of the pulse-count dimmer.
`ifndef PULSE_COUNT_BACKLIGHT_DIMMER_MACROS_SVH
`define PULSE_COUNT_BACKLIGHT_DIMMER_MACROS_SVH

// Clocked, reset-qualified assertion with its own failure message.
`define PCBD_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same, with a generic failure message.
`define PCBD_ASSERT(lbl, prop) `PCBD_ASSERT_MSG(lbl, prop, "pcbd: port check failed")

`endif

// ----- rtl/pcbd_pkg.sv -----
// Types, constants and the microcode table of the pulse-count dimmer.
package pcbd_pkg;

  localparam int LEVEL_W = 6;
  localparam int UPC_W   = 4;

  localparam int RESET_LEVEL_CAP  = 12;
  localparam int RESET_BRIGHTNESS = 160;

  // Line actions, as seen on line_action.
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_OFF     = 3'd1,
    ACT_ON      = 3'd2,
    ACT_PULSE   = 3'd3,
    ACT_LOW_NOW = 3'd4
  } act_e;

  // Input modes.
  localparam logic [1:0] MODE_REQ    = 2'd0;
  localparam logic [1:0] MODE_ON     = 2'd1;
  localparam logic [1:0] MODE_OFF    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_MAX_LEVEL = 3'd0;
  localparam logic [2:0] REG_THR_A     = 3'd1;
  localparam logic [2:0] REG_THR_B     = 3'd2;
  localparam logic [2:0] REG_THR_C     = 3'd3;
  localparam logic [2:0] REG_THR_D     = 3'd4;
  localparam logic [2:0] REG_INVERT    = 3'd5;

  // Datapath operations of one microcode step.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD,
    OP_SCAN,
    OP_STORE,
    OP_EMIT
  } op_e;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER,
    C_IN_ACC,
    C_MODE_OFF,
    C_MODE_BAD,
    C_REQ_DIS,
    C_SCAN_DONE,
    C_TGT_EQ,
    C_TGT_ZERO,
    C_CUR_NZ,
    C_FIRE,
    C_FIRE_LAST
  } cond_e;

  typedef struct packed {
    op_e              op;
    act_e             act;
    cond_e            cond;
    logic             hold;
    logic [UPC_W-1:0] jmp;
  } ctrl_word_t;

  // Program addresses.
  localparam logic [UPC_W-1:0] UA_WAIT    = 4'd0;
  localparam logic [UPC_W-1:0] UA_DISP0   = 4'd1;
  localparam logic [UPC_W-1:0] UA_DISP1   = 4'd2;
  localparam logic [UPC_W-1:0] UA_DISP2   = 4'd3;
  localparam logic [UPC_W-1:0] UA_LOAD    = 4'd4;
  localparam logic [UPC_W-1:0] UA_SCAN    = 4'd5;
  localparam logic [UPC_W-1:0] UA_DEC0    = 4'd6;
  localparam logic [UPC_W-1:0] UA_DEC1    = 4'd7;
  localparam logic [UPC_W-1:0] UA_DEC2    = 4'd8;
  localparam logic [UPC_W-1:0] UA_ON      = 4'd9;
  localparam logic [UPC_W-1:0] UA_CHK     = 4'd10;
  localparam logic [UPC_W-1:0] UA_PULSE   = 4'd11;
  localparam logic [UPC_W-1:0] UA_STORE   = 4'd12;
  localparam logic [UPC_W-1:0] UA_NONE    = 4'd13;
  localparam logic [UPC_W-1:0] UA_OFF     = 4'd14;
  localparam logic [UPC_W-1:0] UA_LOW_NOW = 4'd15;

  // The program. A step jumps when its condition is true; otherwise it either
  // stays (hold) or falls through to the next address.
  function automatic ctrl_word_t ucode(input logic [UPC_W-1:0] pc);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, act: ACT_NONE, cond: C_NEVER, hold: 1'b0, jmp: UA_WAIT};
    case (pc)
      UA_WAIT:    cw = '{OP_ACCEPT, ACT_NONE, C_IN_ACC, 1'b1, UA_DISP0};
      UA_DISP0:   cw = '{OP_NOP, ACT_NONE, C_MODE_OFF, 1'b0, UA_LOW_NOW};
      UA_DISP1:   cw = '{OP_NOP, ACT_NONE, C_MODE_BAD, 1'b0, UA_NONE};
      UA_DISP2:   cw = '{OP_NOP, ACT_NONE, C_REQ_DIS, 1'b0, UA_STORE};
      UA_LOAD:    cw = '{OP_LOAD, ACT_NONE, C_NEVER, 1'b0, UA_WAIT};
      UA_SCAN:    cw = '{OP_SCAN, ACT_NONE, C_SCAN_DONE, 1'b1, UA_DEC0};
      UA_DEC0:    cw = '{OP_NOP, ACT_NONE, C_TGT_EQ, 1'b0, UA_NONE};
      UA_DEC1:    cw = '{OP_NOP, ACT_NONE, C_TGT_ZERO, 1'b0, UA_OFF};
      UA_DEC2:    cw = '{OP_NOP, ACT_NONE, C_CUR_NZ, 1'b0, UA_PULSE};
      UA_ON:      cw = '{OP_EMIT, ACT_ON, C_FIRE, 1'b1, UA_CHK};
      UA_CHK:     cw = '{OP_NOP, ACT_NONE, C_TGT_EQ, 1'b0, UA_WAIT};
      UA_PULSE:   cw = '{OP_EMIT, ACT_PULSE, C_FIRE_LAST, 1'b1, UA_WAIT};
      UA_STORE:   cw = '{OP_STORE, ACT_NONE, C_NEVER, 1'b0, UA_WAIT};
      UA_NONE:    cw = '{OP_EMIT, ACT_NONE, C_FIRE, 1'b1, UA_WAIT};
      UA_OFF:     cw = '{OP_EMIT, ACT_OFF, C_FIRE, 1'b1, UA_WAIT};
      UA_LOW_NOW: cw = '{OP_EMIT, ACT_LOW_NOW, C_FIRE, 1'b1, UA_WAIT};
      default:    cw = '{OP_NOP, ACT_NONE, C_NEVER, 1'b0, UA_WAIT};
    endcase
    return cw;
  endfunction

endpackage

// ----- rtl/pulse_count_backlight_dimmer.sv -----
// Pulse-count backlight dimmer: microcoded controller for a one-wire LED driver.
//
// This block turns brightness requests and switch-on/switch-off events into
// the line actions that step a pulse-counted LED driver to the wanted level.
// Each input transfer, except a request that is only recorded, produces one
// or more result transfers; the final one carries last. Results are switch
// off, switch on (the driver then sits at full level NUM_LEVELS), one pulse
// per level step (each pulse lowers the level by one, with level 1 wrapping
// to NUM_LEVELS), drive low now, or a single "none" result when nothing has
// to change. A request is forced to zero while either blank input is low,
// clamped to max_level_brightness and then mapped to the highest level whose
// threshold it strictly exceeds. A request made while switched off is only
// recorded and produces no result. One item is processed at a time. The
// threshold search visits one level per cycle, and the output register hands
// out one result per cycle while the sink keeps ready high. A write to the
// line polarity register changes nothing here; configuration writes are
// always taken.
module pulse_count_backlight_dimmer #(
  parameter int NUM_LEVELS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [9:0]  requested_brightness_i,
  input  logic        power_unblanked_i,
  input  logic        display_unblanked_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  line_action_o,
  output logic [5:0]  level_after_o,
  output logic [9:0]  stored_brightness_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import pcbd_pkg::*;

  localparam logic [LEVEL_W-1:0] NumLv   = LEVEL_W'(NUM_LEVELS);
  localparam logic [LEVEL_W-1:0] ResetLv =
    (NUM_LEVELS < RESET_LEVEL_CAP) ? NumLv : LEVEL_W'(RESET_LEVEL_CAP);

  // Sequencer.
  logic [UPC_W-1:0] pc_q, pc_d;
  ctrl_word_t       cw;
  logic             cond_true;

  // Configuration.
  logic [7:0]        max_q;
  logic [3:0][63:0]  thr_q;

  // Item and block state.
  logic [1:0]         mode_q, mode_d;
  logic [9:0]         req_q, req_d;
  logic               unbl_q, unbl_d;
  logic [7:0]         r_q, r_d;
  logic [LEVEL_W-1:0] lvl_q, lvl_d;
  logic [LEVEL_W-1:0] tgt_q, tgt_d;
  logic [LEVEL_W-1:0] cur_q, cur_d;
  logic [9:0]         rec_q, rec_d;
  logic               dis_q, dis_d;
  logic [LEVEL_W-1:0] cnt_q, cnt_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  act_e               out_act_q, out_act_d;
  logic [LEVEL_W-1:0] out_lvl_q, out_lvl_d;
  logic [9:0]         out_rec_q, out_rec_d;
  logic               out_last_q, out_last_d;

  // Datapath helpers.
  logic               in_acc, out_free, fire;
  logic [4:0]         thr_idx;
  logic [7:0]         thr_byte;
  logic               hit, scan_done;
  logic [LEVEL_W-1:0] lvl_dec, emit_lvl;
  logic               emit_last;
  logic [9:0]         src;
  logic [7:0]         clamped;

  assign cw = ucode(pc_q);

  assign in_ready_o  = (cw.op == OP_ACCEPT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign fire        = (cw.op == OP_EMIT) && out_free;
  assign cfg_ready_o = 1'b1;

  // Threshold of the level under test: byte (L-1)%8 of word (L-1)/8.
  assign thr_idx   = 5'(lvl_q - LEVEL_W'(1));
  assign thr_byte  = thr_q[thr_idx[4:3]][{thr_idx[2:0], 3'b000} +: 8];
  assign hit       = r_q > thr_byte;
  assign scan_done = hit || (lvl_q == LEVEL_W'(1));

  // One pulse lowers the level; level 1 (or off) wraps to the top.
  assign lvl_dec = (cur_q <= LEVEL_W'(1)) ? NumLv : cur_q - LEVEL_W'(1);

  // Request source, blanking and clamp.
  assign src     = (mode_q == MODE_ON) ? rec_q : req_q;
  assign clamped = !unbl_q ? 8'd0 :
                   (src > {2'b00, max_q}) ? max_q : src[7:0];

  always_comb begin
    case (cw.act)
      ACT_OFF, ACT_LOW_NOW: emit_lvl = '0;
      ACT_ON:               emit_lvl = NumLv;
      ACT_PULSE:            emit_lvl = lvl_dec;
      default:              emit_lvl = cur_q;
    endcase
    case (cw.act)
      ACT_ON:    emit_last = (tgt_q == NumLv);
      ACT_PULSE: emit_last = (lvl_dec == tgt_q) || (cnt_q + LEVEL_W'(1) == NumLv);
      default:   emit_last = 1'b1;
    endcase
  end

  // Jump condition and next step.
  always_comb begin
    case (cw.cond)
      C_IN_ACC:    cond_true = in_acc;
      C_MODE_OFF:  cond_true = (mode_q == MODE_OFF);
      C_MODE_BAD:  cond_true = (mode_q == MODE_UNUSED);
      C_REQ_DIS:   cond_true = (mode_q == MODE_REQ) && dis_q;
      C_SCAN_DONE: cond_true = scan_done;
      C_TGT_EQ:    cond_true = (tgt_q == cur_q);
      C_TGT_ZERO:  cond_true = (tgt_q == '0);
      C_CUR_NZ:    cond_true = (cur_q != '0);
      C_FIRE:      cond_true = fire;
      C_FIRE_LAST: cond_true = fire && emit_last;
      default:     cond_true = 1'b0;
    endcase
    if (cond_true) begin
      pc_d = cw.jmp;
    end else if (cw.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + UPC_W'(1);
    end
  end

  // Datapath driven by the current control word.
  always_comb begin
    mode_d      = mode_q;
    req_d       = req_q;
    unbl_d      = unbl_q;
    r_d         = r_q;
    lvl_d       = lvl_q;
    tgt_d       = tgt_q;
    cur_d       = cur_q;
    rec_d       = rec_q;
    dis_d       = dis_q;
    cnt_d       = cnt_q;
    out_act_d   = out_act_q;
    out_lvl_d   = out_lvl_q;
    out_rec_d   = out_rec_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (cw.op)
      OP_ACCEPT: begin
        if (in_acc) begin
          mode_d = mode_i;
          req_d  = requested_brightness_i;
          unbl_d = power_unblanked_i && display_unblanked_i;
          cnt_d  = '0;
        end
      end
      OP_LOAD: begin
        // Switch-on clears the disabled flag and replays the recorded value.
        if (mode_q == MODE_ON) begin
          dis_d = 1'b0;
        end
        r_d   = clamped;
        rec_d = {2'b00, clamped};
        lvl_d = NumLv;
        tgt_d = '0;
      end
      OP_SCAN: begin
        if (hit) begin
          tgt_d = lvl_q;
        end
        lvl_d = lvl_q - LEVEL_W'(1);
      end
      OP_STORE: begin
        rec_d = req_q;
      end
      OP_EMIT: begin
        if (fire) begin
          cur_d       = emit_lvl;
          cnt_d       = cnt_q + LEVEL_W'(1);
          out_valid_d = 1'b1;
          out_act_d   = cw.act;
          out_lvl_d   = emit_lvl;
          out_rec_d   = rec_q;
          out_last_d  = emit_last;
          if (cw.act == ACT_LOW_NOW) begin
            dis_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= UA_WAIT;
      cur_q       <= ResetLv;
      rec_q       <= 10'(RESET_BRIGHTNESS);
      dis_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      cur_q       <= cur_d;
      rec_q       <= rec_d;
      dis_q       <= dis_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    req_q      <= req_d;
    unbl_q     <= unbl_d;
    r_q        <= r_d;
    lvl_q      <= lvl_d;
    tgt_q      <= tgt_d;
    out_act_q  <= out_act_d;
    out_lvl_q  <= out_lvl_d;
    out_rec_q  <= out_rec_d;
    out_last_q <= out_last_d;
  end

  // Configuration registers. Writes to the polarity register or beyond the
  // register list leave the block unchanged.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 8'hFF;
      thr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MAX_LEVEL: max_q    <= cfg_data_i[7:0];
        REG_THR_A:     thr_q[0] <= cfg_data_i;
        REG_THR_B:     thr_q[1] <= cfg_data_i;
        REG_THR_C:     thr_q[2] <= cfg_data_i;
        REG_THR_D:     thr_q[3] <= cfg_data_i;
        REG_INVERT:    max_q    <= max_q;
        default:       max_q    <= max_q;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign line_action_o       = out_act_q;
  assign level_after_o       = out_lvl_q;
  assign stored_brightness_o = out_rec_q;
  assign last_o              = out_last_q;

endmodule

// ----- rtl/pcbd_checker.sv -----
// Port-level checker for the pulse-count dimmer, bound to its top level.
`include "pulse_count_backlight_dimmer_macros.svh"

module pcbd_checker #(
  parameter int NumLevels = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  line_action_i,
  input logic [5:0]  level_after_i,
  input logic [9:0]  stored_brightness_i,
  input logic        last_i
);
  import pcbd_pkg::*;

  // A stalled result holds still.
  `PCBD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(line_action_i) && $stable(level_after_i) && $stable(stored_brightness_i) && $stable(last_i))

  // Switching off always ends the item with the driver at level zero.
  `PCBD_ASSERT(a_low_now, out_valid_i && line_action_i == ACT_LOW_NOW |-> level_after_i == 6'd0 && last_i)

  `PCBD_ASSERT(a_off, out_valid_i && line_action_i == ACT_OFF |-> level_after_i == 6'd0 && last_i)

  // The driver always powers up at full level.
  `PCBD_ASSERT_MSG(a_on_full, out_valid_i && line_action_i == ACT_ON |-> level_after_i == 6'(NumLevels), "pcbd: switch-on result not at full level")

  // A no-action result is the only result of its item.
  `PCBD_ASSERT(a_none_last, out_valid_i && line_action_i == ACT_NONE |-> last_i)

endmodule

bind pulse_count_backlight_dimmer pcbd_checker #(
  .NumLevels(NUM_LEVELS)
) u_pcbd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .line_action_i      (line_action_o),
  .level_after_i      (level_after_o),
  .stored_brightness_i(stored_brightness_o),
  .last_i             (last_o)
);
